// ===== rtl/tspa_pkg.sv =====
`timescale 1ns / 1ps

package tspa_pkg;

    localparam int DEF_SLOT_COUNT = 16;
    localparam int KIND_COUNT     = 16;

    localparam int KIND_W      = 4;
    localparam int AGE_W       = 16;
    localparam int DT_W        = 10;
    localparam int SLOT_W      = 4;
    localparam int FADE_W      = 9;
    localparam int QUOT_W      = 8;
    localparam int STEP_W      = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_LIFETIME   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FADE_START = 2'd1;

    localparam logic [AGE_W-1:0]  LIFETIME_RESET   = 16'd3000;
    localparam logic [AGE_W-1:0]  FADE_START_RESET = 16'd1800;
    localparam logic [FADE_W-1:0] FADE_ONE         = 9'd256;

    localparam logic [0:0] CMD_ALLOCATE = 1'b0;
    localparam logic [0:0] CMD_TICK     = 1'b1;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              granted;
        logic              kind_reused;
        logic [FADE_W-1:0] fade;
        logic              expired;
        logic              last;
    } result_t;

endpackage

// ===== rtl/timed_slot_pool_allocator_core.sv =====
`timescale 1ns / 1ps
// Allocate: each slot examined gets a flag check, then a RAM kind read if it is free and
// was written before; the result is then handed over before ready returns.
// Tick: each slot's flag is scanned; an active slot is aged, and the eight-step shared
// restoring divider computes its fade inside the fade span; one request at a time.
// Reset is synchronous, active low: flags, pointer and config registers return to defaults.
// The kind/age RAM is not cleared; an entry is only read after its flag says it was written.

module timed_slot_pool_allocator_core #(
    parameter int SLOT_COUNT = tspa_pkg::DEF_SLOT_COUNT
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic [tspa_pkg::KIND_W-1:0]        s_kind,
    input  logic [tspa_pkg::DT_W-1:0]          s_delta_time,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tspa_pkg::SLOT_W-1:0]        m_slot,
    output logic                               m_granted,
    output logic                               m_kind_reused,
    output logic [tspa_pkg::FADE_W-1:0]        m_fade,
    output logic                               m_expired,
    output logic                               m_last,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tspa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tspa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int RAM_W = tspa_pkg::KIND_W + tspa_pkg::AGE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_T_SCAN,
        ST_T_AGE,
        ST_T_DIV,
        ST_T_OUT,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;

    logic [SW-1:0]                   idx_reg, idx_next;
    logic [SW-1:0]                   cnt_reg, cnt_next;
    logic [SW-1:0]                   next_ptr_reg, next_ptr_next;
    logic [tspa_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [tspa_pkg::DT_W-1:0]       dt_reg, dt_next;
    logic [tspa_pkg::AGE_W-1:0]      rem_reg, rem_next;
    logic [tspa_pkg::QUOT_W-1:0]     quot_reg, quot_next;
    logic [tspa_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                            exp_reg, exp_next;
    logic [tspa_pkg::FADE_W-1:0]     fade_reg, fade_next;
    tspa_pkg::result_t               pend_reg, pend_next;
    logic                            pend_valid_reg, pend_valid_next;
    tspa_pkg::result_t               out_reg, out_next;
    logic                            m_valid_reg, m_valid_next;
    logic [SLOT_COUNT-1:0]           active_reg, active_next;
    logic [SLOT_COUNT-1:0]           tagged_reg, tagged_next;
    logic [tspa_pkg::AGE_W-1:0]      lifetime_reg, lifetime_next;
    logic [tspa_pkg::AGE_W-1:0]      fade_start_reg, fade_start_next;

    logic                            ram_we;
    logic [RAM_W-1:0]                ram_wdata;
    logic [RAM_W-1:0]                ram_rdata;

    logic                            slot_is_last;
    logic [SW-1:0]                   idx_inc;
    logic                            out_free;
    logic [tspa_pkg::KIND_W-1:0]     rd_kind;
    logic [tspa_pkg::AGE_W-1:0]      rd_age;
    logic [tspa_pkg::AGE_W:0]        age_sum;
    logic [tspa_pkg::AGE_W-1:0]      age_new;
    logic [tspa_pkg::AGE_W-1:0]      fade_span;
    logic [tspa_pkg::AGE_W:0]        div_shift;
    logic [tspa_pkg::AGE_W:0]        div_diff;
    logic                            div_fits;
    tspa_pkg::result_t               res_grant;
    tspa_pkg::result_t               res_refuse;
    tspa_pkg::result_t               res_tick;

    tspa_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign slot_is_last = (idx_reg == SW'(SLOT_COUNT - 1));
    assign idx_inc      = slot_is_last ? '0 : idx_reg + 1'b1;
    assign out_free     = !m_valid_reg || m_ready;

    assign rd_kind = ram_rdata[RAM_W-1 -: tspa_pkg::KIND_W];
    assign rd_age  = ram_rdata[tspa_pkg::AGE_W-1:0];

    // Age saturates at the top of its range instead of wrapping.
    assign age_sum = {1'b0, rd_age} + (tspa_pkg::AGE_W + 1)'(dt_reg);
    assign age_new = age_sum[tspa_pkg::AGE_W] ? '1 : age_sum[tspa_pkg::AGE_W-1:0];

    // One restoring division step per cycle; the remainder always stays below the span.
    assign fade_span = lifetime_reg - fade_start_reg;
    assign div_shift = {rem_reg, 1'b0};
    assign div_diff  = div_shift - {1'b0, fade_span};
    assign div_fits  = (div_shift >= {1'b0, fade_span});

    always_comb begin
        res_grant = '{slot: tspa_pkg::SLOT_W'(idx_reg), granted: 1'b1, kind_reused: 1'b0,
                      fade: tspa_pkg::FADE_ONE, expired: 1'b0, last: 1'b1};
        res_refuse = '0;
        res_refuse.last = 1'b1;
        res_tick = '{slot: tspa_pkg::SLOT_W'(idx_reg), granted: 1'b0, kind_reused: 1'b0,
                     fade: fade_reg, expired: exp_reg, last: 1'b0};
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        next_ptr_next   = next_ptr_reg;
        kind_next       = kind_reg;
        dt_next         = dt_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        step_next       = step_reg;
        exp_next        = exp_reg;
        fade_next       = fade_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        active_next     = active_reg;
        tagged_next     = tagged_reg;
        lifetime_next   = lifetime_reg;
        fade_start_next = fade_start_reg;
        ram_we          = 1'b0;
        ram_wdata       = {kind_reg, {tspa_pkg::AGE_W{1'b0}}};

        if (cfg_valid) begin
            unique case (cfg_index)
                tspa_pkg::REG_LIFETIME:   lifetime_next   = cfg_data;
                tspa_pkg::REG_FADE_START: fade_start_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next = s_kind;
                    dt_next   = s_delta_time;
                    if (s_command == tspa_pkg::CMD_TICK) begin
                        idx_next   = '0;
                        state_next = ST_T_SCAN;
                    end else if (32'(s_kind) < tspa_pkg::KIND_COUNT) begin
                        idx_next   = next_ptr_reg;
                        cnt_next   = '0;
                        state_next = ST_A_RD;
                    end else begin
                        pend_next       = res_refuse;
                        pend_valid_next = 1'b1;
                        state_next      = ST_FLUSH;
                    end
                end
            end
            ST_A_RD, ST_A_CHK: begin
                if (state_reg == ST_A_RD && !active_reg[idx_reg] && tagged_reg[idx_reg]) begin
                    state_next = ST_A_CHK;
                end else if (!active_reg[idx_reg]
                             && (state_reg == ST_A_RD || rd_kind == kind_reg)) begin
                    ram_we               = 1'b1;
                    active_next[idx_reg] = 1'b1;
                    tagged_next[idx_reg] = 1'b1;
                    next_ptr_next        = idx_inc;
                    pend_next            = res_grant;
                    pend_next.kind_reused = (state_reg == ST_A_CHK);
                    pend_valid_next      = 1'b1;
                    state_next           = ST_FLUSH;
                end else if (cnt_reg == SW'(SLOT_COUNT - 1)) begin
                    pend_next       = res_refuse;
                    pend_valid_next = 1'b1;
                    state_next      = ST_FLUSH;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    idx_next   = idx_inc;
                    state_next = ST_A_RD;
                end
            end
            ST_T_SCAN: begin
                if (active_reg[idx_reg]) begin
                    state_next = ST_T_AGE;
                end else if (slot_is_last) begin
                    state_next = ST_FLUSH;
                end else begin
                    idx_next = idx_inc;
                end
            end
            ST_T_AGE: begin
                ram_we    = 1'b1;
                ram_wdata = {rd_kind, age_new};
                exp_next  = (age_new >= lifetime_reg);
                if (age_new >= lifetime_reg) begin
                    active_next[idx_reg] = 1'b0;
                end
                if (fade_start_reg >= lifetime_reg || age_new >= lifetime_reg) begin
                    fade_next  = '0;
                    state_next = ST_T_OUT;
                end else if (age_new <= fade_start_reg) begin
                    fade_next  = tspa_pkg::FADE_ONE;
                    state_next = ST_T_OUT;
                end else begin
                    rem_next   = lifetime_reg - age_new;
                    quot_next  = '0;
                    step_next  = '0;
                    state_next = ST_T_DIV;
                end
            end
            ST_T_DIV: begin
                rem_next  = div_fits ? div_diff[tspa_pkg::AGE_W-1:0]
                                     : div_shift[tspa_pkg::AGE_W-1:0];
                quot_next = {quot_reg[tspa_pkg::QUOT_W-2:0], div_fits};
                step_next = step_reg + 1'b1;
                if (step_reg == '1) begin
                    fade_next  = {1'b0, quot_next};
                    state_next = ST_T_OUT;
                end
            end
            ST_T_OUT: begin
                // A result is held back until the next one appears, so that the final
                // result of a tick can still be marked as last.
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_next     = pend_reg;
                        m_valid_next = 1'b1;
                    end
                    pend_next       = res_tick;
                    pend_valid_next = 1'b1;
                    if (slot_is_last) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = ST_T_SCAN;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    m_valid_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            next_ptr_reg   <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            active_reg     <= '0;
            tagged_reg     <= '0;
            lifetime_reg   <= tspa_pkg::LIFETIME_RESET;
            fade_start_reg <= tspa_pkg::FADE_START_RESET;
        end else begin
            state_reg      <= state_next;
            next_ptr_reg   <= next_ptr_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            active_reg     <= active_next;
            tagged_reg     <= tagged_next;
            lifetime_reg   <= lifetime_next;
            fade_start_reg <= fade_start_next;
        end
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        kind_reg <= kind_next;
        dt_reg   <= dt_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
        exp_reg  <= exp_next;
        fade_reg <= fade_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_slot        = out_reg.slot;
    assign m_granted     = out_reg.granted;
    assign m_kind_reused = out_reg.kind_reused;
    assign m_fade        = out_reg.fade;
    assign m_expired     = out_reg.expired;
    assign m_last        = out_reg.last;

    a_expired_fades_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_expired |-> m_fade == '0)
        else $error("expired slot reported with a nonzero fade");

    a_grant_is_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_granted |-> m_last && m_fade == tspa_pkg::FADE_ONE && !m_expired)
        else $error("granted allocation result malformed");

    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_T_DIV |-> rem_reg < fade_span)
        else $error("divider remainder not below the fade span");

endmodule

// ===== rtl/tspa_ram.sv =====
`timescale 1ns / 1ps

module tspa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sim/timed_slot_pool_allocator_core_test.sv =====
`timescale 1ns / 1ps

class slot_pool_scoreboard;
    localparam int SLOTS = tspa_pkg::DEF_SLOT_COUNT;
    localparam int unsigned AGE_LIMIT = 65535;

    int unsigned       lifetime;
    int unsigned       fade_start;
    bit                active [SLOTS];
    bit                loaded [SLOTS];
    int unsigned       kind_of [SLOTS];
    int unsigned       age_of [SLOTS];
    int unsigned       next_slot;
    tspa_pkg::result_t awaited_results [$];
    int                errors;

    function new();
        lifetime   = tspa_pkg::LIFETIME_RESET;
        fade_start = tspa_pkg::FADE_START_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            active[i]  = 1'b0;
            loaded[i]  = 1'b0;
            kind_of[i] = 0;
            age_of[i]  = 0;
        end
        next_slot = 0;
        errors    = 0;
    endfunction

    function void set_register(logic [tspa_pkg::CFG_INDEX_W-1:0] index, int unsigned data);
        if (index == tspa_pkg::REG_LIFETIME) begin
            lifetime = data;
        end else if (index == tspa_pkg::REG_FADE_START) begin
            fade_start = data;
        end
    endfunction

    // Visibility in 1/256 steps, falling linearly between fade start and lifetime.
    function int unsigned fade_at(int unsigned age);
        if (fade_start >= lifetime || age >= lifetime) begin
            return 0;
        end
        if (age <= fade_start) begin
            return tspa_pkg::FADE_ONE;
        end
        return (256 * (lifetime - age)) / (lifetime - fade_start);
    endfunction

    function void note_request(logic cmd, logic [tspa_pkg::KIND_W-1:0] kind,
                               logic [tspa_pkg::DT_W-1:0] dt);
        tspa_pkg::result_t r;
        int unsigned       c;
        int unsigned       age;
        int                tail_slot;
        bit                found;
        found = 1'b0;
        r = '0;
        if (cmd == tspa_pkg::CMD_ALLOCATE) begin
            r.last = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                c = (next_slot + i) % SLOTS;
                if (!found && int'(kind) < tspa_pkg::KIND_COUNT && !active[c] &&
                    (!loaded[c] || kind_of[c] == int'(kind))) begin
                    found         = 1'b1;
                    r.slot        = tspa_pkg::SLOT_W'(c);
                    r.granted     = 1'b1;
                    r.kind_reused = loaded[c];
                    r.fade        = tspa_pkg::FADE_ONE;
                    loaded[c]     = 1'b1;
                    kind_of[c]    = kind;
                    age_of[c]     = 0;
                    active[c]     = 1'b1;
                    next_slot     = (c + 1) % SLOTS;
                end
            end
            awaited_results.push_back(r);
        end else begin
            tail_slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (active[i]) begin
                    tail_slot = i;
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (active[i]) begin
                    age = age_of[i] + dt;
                    if (age > AGE_LIMIT) begin
                        age = AGE_LIMIT;
                    end
                    age_of[i] = age;
                    r         = '0;
                    r.slot    = tspa_pkg::SLOT_W'(i);
                    r.fade    = tspa_pkg::FADE_W'(fade_at(age));
                    r.expired = (age >= lifetime);
                    r.last    = (i == tail_slot);
                    if (r.expired) begin
                        active[i] = 1'b0;
                    end
                    awaited_results.push_back(r);
                end
            end
        end
    endfunction

    function void compare_field(string name, int want, int seen);
        if (want != seen) begin
            errors++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, seen);
        end
    endfunction

    function void check_result(tspa_pkg::result_t seen);
        tspa_pkg::result_t want;
        if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, actual slot %0d fade %0d last %0d",
                     $time, seen.slot, seen.fade, seen.last);
            return;
        end
        want = awaited_results.pop_front();
        compare_field("slot", int'(want.slot), int'(seen.slot));
        compare_field("granted", int'(want.granted), int'(seen.granted));
        compare_field("kind_reused", int'(want.kind_reused), int'(seen.kind_reused));
        compare_field("fade", int'(want.fade), int'(seen.fade));
        compare_field("expired", int'(want.expired), int'(seen.expired));
        compare_field("last", int'(want.last), int'(seen.last));
    endfunction
endclass

module timed_slot_pool_allocator_core_test;
    localparam int SETTLE_CYCLES = 240;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 3000;

    logic                             aclk          = 1'b0;
    logic                             aresetn       = 1'b0;
    logic                             s_valid       = 1'b0;
    logic                             s_ready;
    logic                             s_command     = 1'b0;
    logic [tspa_pkg::KIND_W-1:0]      s_kind        = '0;
    logic [tspa_pkg::DT_W-1:0]        s_delta_time  = '0;
    logic                             m_valid;
    logic                             m_ready       = 1'b0;
    logic [tspa_pkg::SLOT_W-1:0]      m_slot;
    logic                             m_granted;
    logic                             m_kind_reused;
    logic [tspa_pkg::FADE_W-1:0]      m_fade;
    logic                             m_expired;
    logic                             m_last;
    logic                             cfg_valid     = 1'b0;
    logic                             cfg_ready;
    logic [tspa_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [tspa_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int          sink_hold      = 0;
    int          quiet_cycles   = 0;

    slot_pool_scoreboard ledger = new();

    timed_slot_pool_allocator_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_kind        (s_kind),
        .s_delta_time  (s_delta_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot        (m_slot),
        .m_granted     (m_granted),
        .m_kind_reused (m_kind_reused),
        .m_fade        (m_fade),
        .m_expired     (m_expired),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // The receiver owns its hold-off counter; otherwise it stalls at random.
    always @(negedge aclk) begin
        if (sink_hold != 0) begin
            m_ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_monitor
        tspa_pkg::result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.slot        = m_slot;
            seen.granted     = m_granted;
            seen.kind_reused = m_kind_reused;
            seen.fade        = m_fade;
            seen.expired     = m_expired;
            seen.last        = m_last;
            ledger.check_result(seen);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [tspa_pkg::KIND_W-1:0] kind,
                             input logic [tspa_pkg::DT_W-1:0] dt);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_kind       <= kind;
        s_delta_time <= dt;
        do @(posedge aclk); while (!s_ready);
        ledger.note_request(cmd, kind, dt);
        @(negedge aclk);
    endtask

    task automatic send_random_item();
        logic                        cmd;
        logic [tspa_pkg::KIND_W-1:0] kind;
        logic [tspa_pkg::DT_W-1:0]   dt;
        cmd = ($urandom_range(99) < 40) ? tspa_pkg::CMD_TICK : tspa_pkg::CMD_ALLOCATE;
        // Half the allocations draw from a few kinds so that reuse is common.
        kind = ($urandom_range(1) != 0) ? tspa_pkg::KIND_W'($urandom_range(3))
                                        : tspa_pkg::KIND_W'($urandom_range(15));
        case ($urandom_range(9))
            0: begin
                dt = '0;
            end
            1: begin
                dt = '1;
            end
            default: begin
                dt = tspa_pkg::DT_W'($urandom_range(1023));
            end
        endcase
        send_item(cmd, kind, dt);
    endtask

    // A tick over an empty pool returns nothing, so the block may still be
    // walking slots when the queue runs dry; the settle time covers that.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (ledger.awaited_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic program_timing(input int unsigned life, input int unsigned start);
        logic [tspa_pkg::CFG_INDEX_W-1:0] index;
        int unsigned                      data;
        for (int r = 0; r < 2; r++) begin
            index = (r == 0) ? tspa_pkg::REG_LIFETIME : tspa_pkg::REG_FADE_START;
            data  = (r == 0) ? life : start;
            cfg_valid <= 1'b1;
            cfg_index <= index;
            cfg_data  <= tspa_pkg::CFG_DATA_W'(data);
            do @(posedge aclk); while (!cfg_ready);
            ledger.set_register(index, data);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned life, input int unsigned start,
                             input int unsigned src_pct, input int unsigned sink_pct,
                             input int count);
        program_timing(life, start);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (count) send_random_item();
        wait_for_results();
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Fill every slot with a distinct kind, then ask once more with the pool full.
        for (int k = 0; k < 16; k++) begin
            send_item(tspa_pkg::CMD_ALLOCATE, tspa_pkg::KIND_W'(k), '0);
        end
        send_item(tspa_pkg::CMD_ALLOCATE, tspa_pkg::KIND_W'(3), '0);
        // Full visibility, partial fade, then expiry of all sixteen slots.
        repeat (3) send_item(tspa_pkg::CMD_TICK, '0, '1);
        send_item(tspa_pkg::CMD_TICK, '1, '0);
        // Kind 7 is found on its old slot; a second request for it has nowhere to go.
        send_item(tspa_pkg::CMD_ALLOCATE, tspa_pkg::KIND_W'(7), '0);
        send_item(tspa_pkg::CMD_ALLOCATE, tspa_pkg::KIND_W'(7), '0);
        send_item(tspa_pkg::CMD_ALLOCATE, tspa_pkg::KIND_W'(15), '1);
        wait_for_results();

        // With a zero lifetime every active slot expires on the next tick.
        program_timing(0, 0);
        send_item(tspa_pkg::CMD_TICK, '0, '0);
        send_item(tspa_pkg::CMD_ALLOCATE, tspa_pkg::KIND_W'(9), '0);
        send_item(tspa_pkg::CMD_TICK, '0, tspa_pkg::DT_W'(5));
        wait_for_results();

        // Drive one slot past the top of the age range.
        program_timing(65535, 65534);
        send_item(tspa_pkg::CMD_ALLOCATE, tspa_pkg::KIND_W'(2), '0);
        repeat (65) send_item(tspa_pkg::CMD_TICK, '0, '1);
        wait_for_results();

        run_phase(3000, 1800, 0, 0, 16);
        run_phase(1, 0, 77, 0, 16);
        run_phase(65535, 0, 0, 77, 16);
        run_phase(1200, 300, 35, 35, 16);
        run_phase(2000, 65534, 35, 35, 8);

        // Back-pressure: the receiver stops while requests keep coming.
        program_timing(4000, 1000);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold      = LONG_HOLD;
        repeat (15) send_random_item();
        wait_for_results();
        repeat (5) send_random_item();
        wait_for_results();

        if (ledger.awaited_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     ledger.awaited_results.size());
        end
        if (ledger.errors == 0 && ledger.awaited_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
